### hw/rtl/pstvp_pkg.sv
package pstvp_pkg;

  localparam int MaxVertices = 64;
  localparam int IdxW = $clog2(MaxVertices);
  localparam int CntW = $clog2(MaxVertices + 1);
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               polygon_dropped;
    logic               last_out;
  } out_item_t;

  // Item moved from the front to the back through the queue.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               store;
    logic               close;
  } cmd_t;

endpackage

### hw/rtl/pstvp_front.sv
module pstvp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  pstvp_pkg::in_item_t in_data,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output pstvp_pkg::cmd_t     cmd
);
  import pstvp_pkg::*;

  logic [CntW-1:0] count;

  assign cmd_valid = in_valid;
  assign in_ready  = cmd_ready;
  assign cmd.x     = in_data.vertex_x;
  assign cmd.y     = in_data.vertex_y;
  assign cmd.store = (count < CntW'(MaxVertices));
  assign cmd.close = in_data.last_vertex;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_valid && cmd_ready) begin
      if (in_data.last_vertex) begin
        count <= '0;
      end else if (count < CntW'(MaxVertices)) begin
        count <= count + 1'b1;
      end
    end
  end
endmodule

### hw/rtl/pstvp_queue.sv
module pstvp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  pstvp_pkg::cmd_t  wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output pstvp_pkg::cmd_t  rd_data
);
  import pstvp_pkg::*;

  cmd_t            slots [QDepth];
  logic [QPtrW-1:0] wptr, rptr;
  logic [QPtrW:0]   fill;
  logic            do_wr, do_rd;

  assign wr_ready = (fill != (QPtrW+1)'(QDepth));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) fill <= fill + 1'b1;
      else if (!do_wr && do_rd) fill <= fill - 1'b1;
    end
  end
endmodule

### hw/rtl/pstvp_back.sv
module pstvp_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [31:0]          area_threshold,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  pstvp_pkg::cmd_t      cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pstvp_pkg::out_item_t out_data
);
  import pstvp_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD = 8'b00000001,
    S_RD0  = 8'b00000010,
    S_RD1  = 8'b00000100,
    S_RD2  = 8'b00001000,
    S_MUL  = 8'b00010000,
    S_CMP  = 8'b00100000,
    S_SHIFT = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  state_t state;
  logic [31:0] mem [MaxVertices];
  logic [31:0] rdata;
  logic [IdxW-1:0] raddr;
  logic        wen;
  logic [IdxW-1:0] waddr;
  logic [31:0] wdata;

  logic [CntW-1:0] n, wcnt;
  logic [IdxW-1:0] pos, sh;
  logic            final_chk;
  logic [31:0]     va, vb, vc;
  logic signed [34:0] p0, p1, p2;
  logic signed [36:0] s;
  logic [35:0]     dabs;
  logic            tri_small;
  logic [IdxW-1:0] emit_i;
  logic            emit_drop, emit_wait;
  logic [IdxW-1:0] left_i, right_i;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign left_i  = (pos == '0) ? IdxW'(n - 1'b1) : pos - 1'b1;
  assign right_i = (CntW'(pos) + 1'b1 == n) ? '0 : pos + 1'b1;

  always_comb begin
    raddr = left_i;
    priority case (1'b1)
      state == S_LOAD:  raddr = left_i;
      state == S_RD0:   raddr = pos;
      state == S_RD1:   raddr = right_i;
      state == S_SHIFT: raddr = IdxW'(CntW'(sh) + 1'b1);
      state == S_EMIT:  raddr = emit_i;
      default:          raddr = left_i;
    endcase
  end

  assign cmd_ready = (state == S_LOAD);
  assign s    = 37'(p0) + 37'(p1) + 37'(p2);
  assign dabs = s[36] ? 36'(-s) : 36'(s);
  assign tri_small = ({1'b0, dabs} < {4'b0, area_threshold, 1'b0});

  always_comb begin
    wen   = 1'b0;
    waddr = wcnt[IdxW-1:0];
    wdata = {cmd.y, cmd.x};
    if (state == S_LOAD && cmd_valid && cmd.store) wen = 1'b1;
    if (state == S_SHIFT && emit_wait) begin
      wen = 1'b1;
      waddr = sh;
      wdata = rdata;
    end
  end

  always_ff @(posedge clk) begin
    p0 <= 35'(signed'(va[15:0])) * 35'(signed'(vb[31:16]) - signed'(vc[31:16]));
    p1 <= 35'(signed'(vc[15:0])) * 35'(signed'(va[31:16]) - signed'(vb[31:16]));
    p2 <= 35'(signed'(vb[15:0])) * 35'(signed'(vc[31:16]) - signed'(va[31:16]));
    if (rst) begin
      state <= S_LOAD;
      wcnt <= '0;
      out_valid <= 1'b0;
      emit_wait <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cmd_valid) begin
            n <= wcnt + CntW'(cmd.store);
            wcnt <= cmd.close ? '0 : wcnt + CntW'(cmd.store);
            if (cmd.close) begin
              pos <= '0;
              if (wcnt + CntW'(cmd.store) < CntW'(3)) begin
                emit_drop <= 1'b1;
                emit_i <= '0;
                state <= S_EMIT;
                emit_wait <= 1'b0;
              end else begin
                final_chk <= (wcnt + CntW'(cmd.store) == CntW'(3));
                state <= S_RD0;
              end
            end
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: begin va <= rdata; state <= S_RD2; end
        S_RD2: begin vb <= rdata; state <= S_MUL; end
        S_MUL: begin vc <= rdata; state <= S_CMP; emit_wait <= 1'b0; end
        S_CMP: begin
          if (!emit_wait) begin
            emit_wait <= 1'b1;
          end else if (final_chk) begin
            emit_drop <= tri_small;
            emit_i <= '0;
            emit_wait <= 1'b0;
            state <= S_EMIT;
          end else if (tri_small) begin
            sh <= pos;
            n <= n - 1'b1;
            emit_wait <= 1'b0;
            state <= S_SHIFT;
          end else if (CntW'(pos) + 1'b1 == n) begin
            emit_drop <= 1'b0;
            emit_i <= '0;
            emit_wait <= 1'b0;
            state <= S_EMIT;
          end else begin
            pos <= pos + 1'b1;
            state <= S_RD0;
          end
        end
        S_SHIFT: begin
          // Move entry sh+1 down to sh: the entry is read from memory, then written back one place lower.
          if (CntW'(sh) >= n) begin
            pos <= '0;
            final_chk <= (n == CntW'(3));
            state <= S_RD0;
            emit_wait <= 1'b0;
          end else if (!emit_wait) begin
            emit_wait <= 1'b1;
          end else begin
            sh <= sh + 1'b1;
            emit_wait <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && out_data.last_out) begin
              out_valid <= 1'b0;
              state <= S_LOAD;
            end else if (!emit_wait) begin
              out_valid <= 1'b0;
              emit_wait <= 1'b1;
            end else begin
              out_valid <= 1'b1;
              out_data.out_x <= emit_drop ? '0 : rdata[15:0];
              out_data.out_y <= emit_drop ? '0 : rdata[31:16];
              out_data.polygon_dropped <= emit_drop;
              out_data.last_out <= emit_drop || (CntW'(emit_i) + 1'b1 == n);
              emit_i <= emit_i + 1'b1;
              emit_wait <= 1'b0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

### hw/rtl/polygon_small_triangle_vertex_pruner_top.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    pstvp_pkg::in_item_t
// out      output     out_valid/out_ready  pstvp_pkg::out_item_t
// cfg      input      cfg_valid/cfg_ready  area_threshold, 32 bits
// A vertex that does not close its polygon passes through a four-entry queue to the back end.
// The closing vertex starts a scan over the vertices tested, with the later entries moved
// down after each removal.
// A stalled output holds the back end, which takes no new vertex until its results are out.
// Reset is synchronous and sets the threshold to 256.
module polygon_small_triangle_vertex_pruner_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pstvp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pstvp_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [31:0]          cfg_data
);
  import pstvp_pkg::*;

  logic [31:0] area_threshold;
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t        fq_cmd, qb_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_threshold <= 32'd256;
    end else if (cfg_valid) begin
      area_threshold <= cfg_data;
    end
  end

  pstvp_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data,
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
  );

  pstvp_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
  );

  pstvp_back u_back (
    .clk, .rst, .area_threshold,
    .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
    .out_valid, .out_ready, .out_data
  );
endmodule

### hw/rtl/pstvp_checker.sv
module pstvp_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input pstvp_pkg::out_item_t out_data
);
  import pstvp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out held");

  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.polygon_dropped |-> out_data.last_out &&
    out_data.out_x == 16'sd0 && out_data.out_y == 16'sd0) else $error("drop item");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_out |=> !out_valid) else $error("gap");
endmodule

bind polygon_small_triangle_vertex_pruner_top pstvp_checker u_checker (
  .clk, .rst, .out_valid, .out_ready, .out_data
);
